// ----- design/pileup_column_base_profiler_core_macros.svh -----
// Assertion helpers used by the profiler top level.
`ifndef PILEUP_COLUMN_BASE_PROFILER_CORE_MACROS_SVH
`define PILEUP_COLUMN_BASE_PROFILER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PCBP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PCBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pcbp_pkg.sv -----
`default_nettype none
package pcbp_pkg;

  localparam int NUM_BASES = 5;
  localparam int BASE_IDX_BITS = $clog2(NUM_BASES);
  localparam int DEF_COUNT_BITS = 16;
  localparam int DEF_QUEUE_DEPTH = 2;
  localparam int OUT_BITS = 16;
  localparam int RATIO_BITS = 17;
  localparam logic [RATIO_BITS-1:0] Q_ONE = 17'h10000;

  typedef logic [BASE_IDX_BITS-1:0] base_idx_t;

  localparam logic [7:0] BASE_CODES [NUM_BASES] = '{8'h41, 8'h43, 8'h47, 8'h4E, 8'h54};

  typedef struct packed {
    logic [7:0]            ref_char;
    logic [OUT_BITS-1:0]   coverage;
    logic [RATIO_BITS-1:0] min_ratio;
    logic                  gate;
    logic [OUT_BITS-1:0]   length;
  } col_meta_t;

endpackage
`default_nettype wire

// ----- design/pcbp_front.sv -----
`default_nettype none
module pcbp_front #(
  parameter int COUNT_BITS = pcbp_pkg::DEF_COUNT_BITS
) (
  input  wire logic                                                 clk,
  input  wire logic                                                 rst,
  input  wire logic                                                 accept,
  input  wire logic [7:0]                                           base_char,
  input  wire logic                                                 last,
  input  wire logic [7:0]                                           reference_char,
  input  wire logic [pcbp_pkg::OUT_BITS-1:0]                        coverage,
  input  wire logic [pcbp_pkg::RATIO_BITS-1:0]                      min_ratio,
  input  wire logic                                                 gate_enable,
  output logic                                                      rec_wr,
  output logic [pcbp_pkg::NUM_BASES-1:0][COUNT_BITS-1:0]            rec_counts,
  output pcbp_pkg::col_meta_t                                       rec_meta
);
  import pcbp_pkg::*;

  localparam int EXT = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  logic [NUM_BASES-1:0][COUNT_BITS-1:0] cnt;
  logic [NUM_BASES-1:0][COUNT_BITS-1:0] cnt_next;
  logic [COUNT_BITS-1:0]                len;
  logic [COUNT_BITS-1:0]                len_next;
  logic [EXT-1:0]                       len_ext;

  always_comb begin
    for (int i = 0; i < NUM_BASES; i++) begin
      if (base_char == BASE_CODES[i] && cnt[i] != '1) begin
        cnt_next[i] = cnt[i] + 1'b1;
      end else begin
        cnt_next[i] = cnt[i];
      end
    end
    len_next = (len == '1) ? len : len + 1'b1;
    len_ext  = EXT'(len_next);
  end

  assign rec_wr     = accept && last;
  assign rec_counts = cnt_next;

  always_comb begin
    rec_meta.ref_char  = reference_char;
    rec_meta.coverage  = coverage;
    rec_meta.min_ratio = min_ratio;
    rec_meta.gate      = gate_enable;
    rec_meta.length    = (len_ext > EXT'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                                                             : len_ext[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      len <= '0;
    end else if (accept) begin
      if (last) begin
        cnt <= '0;
        len <= '0;
      end else begin
        cnt <= cnt_next;
        len <= len_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/pcbp_queue.sv -----
`default_nettype none
module pcbp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcbp_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    fill;

  assign full  = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({wr && !full, rd && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/pcbp_back.sv -----
`default_nettype none
module pcbp_back #(
  parameter int COUNT_BITS = pcbp_pkg::DEF_COUNT_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      rec_avail,
  output logic                                           rec_rd,
  input  wire logic [pcbp_pkg::NUM_BASES-1:0][COUNT_BITS-1:0] rec_counts,
  input  wire pcbp_pkg::col_meta_t                       rec_meta,
  input  wire logic                                      pop,
  output logic                                           empty,
  output logic [pcbp_pkg::OUT_BITS-1:0]                  count_a,
  output logic [pcbp_pkg::OUT_BITS-1:0]                  count_c,
  output logic [pcbp_pkg::OUT_BITS-1:0]                  count_g,
  output logic [pcbp_pkg::OUT_BITS-1:0]                  count_n,
  output logic [pcbp_pkg::OUT_BITS-1:0]                  count_t,
  output logic [2:0]                                     competing_low,
  output logic [2:0]                                     competing_high,
  output logic [pcbp_pkg::RATIO_BITS-1:0]                departure,
  output logic [pcbp_pkg::OUT_BITS-1:0]                  used_coverage
);
  import pcbp_pkg::*;

  localparam int EXT = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
  localparam int SW  = COUNT_BITS + 3;
  localparam int CW  = (SW > OUT_BITS) ? SW : OUT_BITS;
  localparam int SB  = $clog2(OUT_BITS);

  typedef enum logic [2:0] {IDLE, SUM, PICK, DIV, FIN} state_t;

  state_t                              state;
  logic [NUM_BASES-1:0][COUNT_BITS-1:0] cnt;
  col_meta_t                           meta;
  logic [SW-1:0]                       nonref;
  logic [SW-1:0]                       nonref_next;
  base_idx_t                           top1;
  base_idx_t                           top2_next;
  logic [2:0]                          pair_low;
  logic [2:0]                          pair_high;
  logic [OUT_BITS-1:0]                 divisor;
  logic [OUT_BITS-1:0]                 rem;
  logic [OUT_BITS-1:0]                 quo;
  logic [SB-1:0]                       step;
  logic [RATIO_BITS-1:0]               dep;
  logic [RATIO_BITS-1:0]               dep_gated;
  logic [OUT_BITS:0]                   trial;
  logic                                out_valid;

  function automatic base_idx_t pick_top(
    input logic [NUM_BASES-1:0][COUNT_BITS-1:0] c,
    input base_idx_t skip
  );
    base_idx_t best;
    logic      found;
    best  = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_BASES; i++) begin
      if (base_idx_t'(i) != skip) begin
        if (!found || c[i] >= c[best]) begin
          best  = base_idx_t'(i);
          found = 1'b1;
        end
      end
    end
    return best;
  endfunction

  function automatic logic [OUT_BITS-1:0] clip16(input logic [COUNT_BITS-1:0] v);
    logic [EXT-1:0] e;
    e = EXT'(v);
    return (e > EXT'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : e[OUT_BITS-1:0];
  endfunction

  always_comb begin
    nonref_next = '0;
    for (int i = 0; i < NUM_BASES; i++) begin
      if (BASE_CODES[i] != meta.ref_char) begin
        nonref_next = nonref_next + SW'(cnt[i]);
      end
    end
    top2_next = pick_top(cnt, top1);
    trial     = {rem, 1'b0};
    dep_gated = (meta.gate && !(dep > meta.min_ratio)) ? '0 : dep;
  end

  assign empty  = !out_valid;
  assign rec_rd = (state == IDLE) && rec_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (rec_avail) begin
            cnt     <= rec_counts;
            meta    <= rec_meta;
            divisor <= (rec_meta.coverage != '0) ? rec_meta.coverage : rec_meta.length;
            state   <= SUM;
          end
        end
        SUM: begin
          nonref <= nonref_next;
          top1   <= pick_top(cnt, base_idx_t'(NUM_BASES));
          state  <= PICK;
        end
        PICK: begin
          if (top1 < top2_next) begin
            pair_low  <= 3'(top1);
            pair_high <= 3'(top2_next);
          end else begin
            pair_low  <= 3'(top2_next);
            pair_high <= 3'(top1);
          end
          if (divisor == '0) begin
            dep   <= '0;
            state <= FIN;
          end else if (CW'(nonref) >= CW'(divisor)) begin
            dep   <= Q_ONE;
            state <= FIN;
          end else begin
            rem   <= OUT_BITS'(nonref);
            quo   <= '0;
            step  <= '0;
            state <= DIV;
          end
        end
        DIV: begin
          if (trial >= {1'b0, divisor}) begin
            rem <= OUT_BITS'(trial - {1'b0, divisor});
            quo <= {quo[OUT_BITS-2:0], 1'b1};
          end else begin
            rem <= trial[OUT_BITS-1:0];
            quo <= {quo[OUT_BITS-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == SB'(OUT_BITS - 1)) begin
            dep   <= {1'b0, quo[OUT_BITS-2:0], (trial >= {1'b0, divisor})};
            state <= FIN;
          end
        end
        FIN: begin
          if (!out_valid || pop) begin
            count_a        <= clip16(cnt[0]);
            count_c        <= clip16(cnt[1]);
            count_g        <= clip16(cnt[2]);
            count_n        <= clip16(cnt[3]);
            count_t        <= clip16(cnt[4]);
            competing_low  <= pair_low;
            competing_high <= pair_high;
            departure      <= dep_gated;
            used_coverage  <= divisor;
            out_valid      <= 1'b1;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/pileup_column_base_profiler_core.sv -----
// Pileup column base profiler.
// Input channel: one column character per transaction (push/full). The
// transaction with last high closes the column; reference_char, coverage,
// min_ratio and gate_enable are sampled on it only.
// Output channel: one result per column (empty/pop), holding the five base
// counts, the top two bases, the departure ratio and the divisor used.
// Throughput: one character per cycle while full is low. Each closed column
// is queued to a result engine that takes one column at a time; it loads
// the column, sums non-reference counts and picks the leader, picks the
// runner-up, runs the bit-serial divide when needed and writes the result
// register.
// A short queue of closed columns sits between counter and engine; when it
// fills, full rises and holds the input until the engine frees an entry.
// A stalled receiver holds the result register and, in turn, the engine.
// Reset clears the counters and the queue, empties the result register and idles the engine.
`default_nettype none
`include "pileup_column_base_profiler_core_macros.svh"
module pileup_column_base_profiler_core #(
  parameter int COUNT_BITS  = pcbp_pkg::DEF_COUNT_BITS,
  parameter int QUEUE_DEPTH = pcbp_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [7:0]                        base_char,
  input  wire logic                              last,
  input  wire logic [7:0]                        reference_char,
  input  wire logic [pcbp_pkg::OUT_BITS-1:0]     coverage,
  input  wire logic [pcbp_pkg::RATIO_BITS-1:0]   min_ratio,
  input  wire logic                              gate_enable,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [pcbp_pkg::OUT_BITS-1:0]          count_a,
  output logic [pcbp_pkg::OUT_BITS-1:0]          count_c,
  output logic [pcbp_pkg::OUT_BITS-1:0]          count_g,
  output logic [pcbp_pkg::OUT_BITS-1:0]          count_n,
  output logic [pcbp_pkg::OUT_BITS-1:0]          count_t,
  output logic [2:0]                             competing_low,
  output logic [2:0]                             competing_high,
  output logic [pcbp_pkg::RATIO_BITS-1:0]        departure,
  output logic [pcbp_pkg::OUT_BITS-1:0]          used_coverage
);
  import pcbp_pkg::*;

  localparam int QW = NUM_BASES * COUNT_BITS + $bits(col_meta_t);

  logic                                 accept;
  logic                                 f_wr;
  logic [NUM_BASES-1:0][COUNT_BITS-1:0] f_counts;
  col_meta_t                            f_meta;
  logic [QW-1:0]                        q_rdata;
  logic                                 q_empty;
  logic                                 q_rd;
  logic [NUM_BASES-1:0][COUNT_BITS-1:0] b_counts;
  col_meta_t                            b_meta;

  assign accept = push && !full;
  assign {b_counts, b_meta} = q_rdata;

  pcbp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .base_char      (base_char),
    .last           (last),
    .reference_char (reference_char),
    .coverage       (coverage),
    .min_ratio      (min_ratio),
    .gate_enable    (gate_enable),
    .rec_wr         (f_wr),
    .rec_counts     (f_counts),
    .rec_meta       (f_meta)
  );

  pcbp_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_wr),
    .wdata ({f_counts, f_meta}),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  pcbp_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .rec_avail      (!q_empty),
    .rec_rd         (q_rd),
    .rec_counts     (b_counts),
    .rec_meta       (b_meta),
    .pop            (pop),
    .empty          (empty),
    .count_a        (count_a),
    .count_c        (count_c),
    .count_g        (count_g),
    .count_n        (count_n),
    .count_t        (count_t),
    .competing_low  (competing_low),
    .competing_high (competing_high),
    .departure      (departure),
    .used_coverage  (used_coverage)
  );

  `PCBP_ASSERT_IMPL(a_dep_range, clk, rst, !empty, departure <= Q_ONE, "departure above 1.0")
  `PCBP_ASSERT_IMPL(a_pair_order, clk, rst, !empty, competing_low < competing_high,
                    "top bases out of order")
  `PCBP_ASSERT_IMPL(a_zero_div, clk, rst, !empty && used_coverage == '0, departure == '0,
                    "departure with empty divisor")
  `PCBP_ASSERT_NEXT(a_column_kept, clk, rst, accept && last, !q_empty || q_rd,
                    "closed column lost")

endmodule
`default_nettype wire
